// ===== src/bpq_pkg.sv =====
package bpq_pkg;

  // Fixed field widths.
  localparam int CNT_W    = 4;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;

  // Request modes, carried on the slave-side tuser.
  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP_TOP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POP_LOW = 2'd3;

  // Result status codes, carried on the master-side tuser.
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EVICTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

  // Chain operations broadcast to every cell.
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Which cell a removal starts at.
  localparam logic [1:0] SEL_MATCH = 2'd0;
  localparam logic [1:0] SEL_TOP   = 2'd1;
  localparam logic [1:0] SEL_LAST  = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] sel;
  } cell_ctl_t;

endpackage

// ===== src/bounded_priority_queue_evict_min.sv =====
// Bounded max-priority queue of up to CAPACITY tagged entries, kept sorted by
// descending priority in a chain of cells, highest at the top. Each request
// (mode on s_axis_tuser) gives exactly one result (status on m_axis_tuser).
// An insert whose tag and condition count match a stored entry updates that
// entry; on a full queue an insert below the minimum is dropped, otherwise the
// minimum is evicted and returned. Among equal priorities the older entry sits
// nearer the top. Each request passes through an execute state, where the chain
// operation is chosen and run, and a push state that loads the output register;
// an update or an eviction adds an insertion state between them, since the
// chain does a removal pass and then an insertion pass. A new request is taken
// while the previous result still waits in the output register, but a result
// that is not drained stalls the block in its push state.
module bounded_priority_queue_evict_min
  import bpq_pkg::*;
#(
  parameter int CAPACITY       = 16,
  parameter int TAG_WIDTH      = 16,
  parameter int PRIORITY_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // entry_tag, cond_count, priority_req (lowest bit first), zero filled
  input  logic [((TAG_WIDTH+CNT_W+PRIORITY_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // mode
  input  logic [MODE_W-1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_tag, out_cond_count, out_priority, occupancy, queue_empty
  // (lowest bit first), zero filled
  output logic [((TAG_WIDTH+CNT_W+PRIORITY_WIDTH+$clog2(CAPACITY+1)+1+7)/8)*8-1:0]
               m_axis_tdata,
  // status
  output logic [STATUS_W-1:0] m_axis_tuser
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int OUT_W = ((TAG_WIDTH + CNT_W + PRIORITY_WIDTH + CW + 1 + 7) / 8) * 8;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_INS  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Registered request.
  logic [MODE_W-1:0]         req_mode;
  logic [TAG_WIDTH-1:0]      req_tag;
  logic [CNT_W-1:0]          req_cnt;
  logic [PRIORITY_WIDTH-1:0] req_pri;

  // Pending result.
  logic [STATUS_W-1:0]       res_status;
  logic [TAG_WIDTH-1:0]      res_tag;
  logic [CNT_W-1:0]          res_cnt;
  logic [PRIORITY_WIDTH-1:0] res_pri;

  logic [CW-1:0] count;

  // Chain wiring.
  cell_ctl_t                 ctl;
  logic [CAPACITY-1:0]       c_valid;
  logic [CAPACITY-1:0]       c_goes;
  logic [CAPACITY-1:0]       c_match;
  logic [CAPACITY-1:0]       c_tail;
  logic [CAPACITY-1:0]       c_shift;
  logic [TAG_WIDTH-1:0]      c_tag [CAPACITY];
  logic [CNT_W-1:0]          c_cnt [CAPACITY];
  logic [PRIORITY_WIDTH-1:0] c_pri [CAPACITY];

  // Execute-cycle decisions.
  cell_ctl_t                 exec_ctl;
  logic [STATUS_W-1:0]       exec_status;
  logic [TAG_WIDTH-1:0]      exec_tag;
  logic [CNT_W-1:0]          exec_cnt;
  logic [PRIORITY_WIDTH-1:0] exec_pri;
  logic                      exec_ins;

  logic [TAG_WIDTH-1:0]      tail_tag;
  logic [CNT_W-1:0]          tail_cnt;
  logic [PRIORITY_WIDTH-1:0] tail_pri;

  logic any_match;
  logic full;
  logic empty;
  logic below_min;
  logic out_free;
  logic in_accept;

  // Handshake.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !rst && ((state == S_IDLE) || ((state == S_PUSH) && out_free));
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // The cell chain.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      up_valid;
    logic                      up_goes;
    logic [TAG_WIDTH-1:0]      up_tag;
    logic [CNT_W-1:0]          up_cnt;
    logic [PRIORITY_WIDTH-1:0] up_pri;
    logic                      dn_valid;
    logic [TAG_WIDTH-1:0]      dn_tag;
    logic [CNT_W-1:0]          dn_cnt;
    logic [PRIORITY_WIDTH-1:0] dn_pri;
    logic                      shift_in;

    if (i == 0) begin : g_top
      // Above the top cell sits an always-valid entry that never moves.
      assign up_valid = 1'b1;
      assign up_goes  = 1'b1;
      assign up_tag   = '0;
      assign up_cnt   = '0;
      assign up_pri   = '0;
      assign shift_in = (ctl.op == OP_REMOVE) && (ctl.sel == SEL_TOP);
    end else begin : g_mid
      assign up_valid = c_valid[i-1];
      assign up_goes  = c_goes[i-1];
      assign up_tag   = c_tag[i-1];
      assign up_cnt   = c_cnt[i-1];
      assign up_pri   = c_pri[i-1];
      assign shift_in = c_shift[i-1];
    end

    if (i == CAPACITY - 1) begin : g_bot
      assign dn_valid = 1'b0;
      assign dn_tag   = '0;
      assign dn_cnt   = '0;
      assign dn_pri   = '0;
    end else begin : g_inner
      assign dn_valid = c_valid[i+1];
      assign dn_tag   = c_tag[i+1];
      assign dn_cnt   = c_cnt[i+1];
      assign dn_pri   = c_pri[i+1];
    end

    bpq_cell #(
      .TAG_WIDTH      (TAG_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .key_tag   (req_tag),
      .key_cnt   (req_cnt),
      .key_pri   (req_pri),
      .up_valid  (up_valid),
      .up_goes   (up_goes),
      .up_tag    (up_tag),
      .up_cnt    (up_cnt),
      .up_pri    (up_pri),
      .dn_valid  (dn_valid),
      .dn_tag    (dn_tag),
      .dn_cnt    (dn_cnt),
      .dn_pri    (dn_pri),
      .shift_in  (shift_in),
      .valid     (c_valid[i]),
      .tag       (c_tag[i]),
      .cnt       (c_cnt[i]),
      .pri       (c_pri[i]),
      .goes      (c_goes[i]),
      .match     (c_match[i]),
      .tail      (c_tail[i]),
      .shift_out (c_shift[i])
    );
  end

  // Gather the lowest stored entry and the queue flags.
  always_comb begin
    tail_tag = '0;
    tail_cnt = '0;
    tail_pri = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (c_tail[i]) begin
        tail_tag |= c_tag[i];
        tail_cnt |= c_cnt[i];
        tail_pri |= c_pri[i];
      end
    end
    any_match = |c_match;
    full      = (count == CW'(CAPACITY));
    empty     = (count == '0);
    below_min = (req_pri < c_pri[CAPACITY-1]);
  end

  // Decide the chain operation and the result of a request.
  always_comb begin
    exec_ctl.op  = OP_HOLD;
    exec_ctl.sel = SEL_MATCH;
    exec_status  = ST_EMPTY;
    exec_tag     = '0;
    exec_cnt     = '0;
    exec_pri     = '0;
    exec_ins     = 1'b0;
    case (req_mode)
      MODE_INSERT: begin
        if (any_match) begin
          // Update: take the old entry out, then place it again.
          exec_ctl.op  = OP_REMOVE;
          exec_ctl.sel = SEL_MATCH;
          exec_status  = ST_UPDATED;
          exec_ins     = 1'b1;
        end else if (full) begin
          if (below_min) begin
            exec_status = ST_DROPPED;
          end else begin
            exec_ctl.op  = OP_REMOVE;
            exec_ctl.sel = SEL_LAST;
            exec_status  = ST_EVICTED;
            exec_tag     = tail_tag;
            exec_cnt     = tail_cnt;
            exec_pri     = tail_pri;
            exec_ins     = 1'b1;
          end
        end else begin
          exec_ctl.op = OP_INSERT;
          exec_status = ST_INSERTED;
        end
      end
      MODE_POP_TOP: begin
        if (!empty) begin
          exec_ctl.op  = OP_REMOVE;
          exec_ctl.sel = SEL_TOP;
          exec_status  = ST_READ_OK;
          exec_tag     = c_tag[0];
          exec_cnt     = c_cnt[0];
          exec_pri     = c_pri[0];
        end
      end
      MODE_PEEK: begin
        if (!empty) begin
          exec_status = ST_READ_OK;
          exec_tag    = c_tag[0];
          exec_cnt    = c_cnt[0];
          exec_pri    = c_pri[0];
        end
      end
      default: begin
        if (!empty) begin
          exec_ctl.op  = OP_REMOVE;
          exec_ctl.sel = SEL_LAST;
          exec_status  = ST_READ_OK;
          exec_tag     = tail_tag;
          exec_cnt     = tail_cnt;
          exec_pri     = tail_pri;
        end
      end
    endcase
  end

  // Operation broadcast to the chain in the current state.
  always_comb begin
    ctl.op  = OP_HOLD;
    ctl.sel = SEL_MATCH;
    if (state == S_EXEC) begin
      ctl = exec_ctl;
    end else if (state == S_INS) begin
      ctl.op = OP_INSERT;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = exec_ins ? S_INS : S_PUSH;
      end
      S_INS: begin
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (in_accept) begin
          state_next = S_EXEC;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.op == OP_INSERT) begin
        count <= count + CW'(1);
      end else if (ctl.op == OP_REMOVE) begin
        count <= count - CW'(1);
      end
      if ((state == S_PUSH) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Request, pending result and output payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_mode <= s_axis_tuser;
      req_tag  <= s_axis_tdata[TAG_WIDTH-1:0];
      req_cnt  <= s_axis_tdata[TAG_WIDTH+CNT_W-1:TAG_WIDTH];
      req_pri  <= s_axis_tdata[TAG_WIDTH+CNT_W+PRIORITY_WIDTH-1:TAG_WIDTH+CNT_W];
    end
    if (state == S_EXEC) begin
      res_status <= exec_status;
      res_tag    <= exec_tag;
      res_cnt    <= exec_cnt;
      res_pri    <= exec_pri;
    end
    if ((state == S_PUSH) && out_free) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= OUT_W'({(count == '0), count, res_pri, res_cnt, res_tag});
    end
  end

  // The fill count always equals the number of valid cells.
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    int'(count) == $countones(c_valid))
    else $error("fill count differs from the number of valid cells");

  // The insertion pass after a removal never runs on a full chain.
  a_ins_not_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS) |-> (count < CW'(CAPACITY)))
    else $error("insertion pass on a full chain");

  // The top two entries stay in descending order.
  a_top_ordered: assert property (@(posedge clk) disable iff (rst)
    c_valid[1] |-> (c_pri[0] >= c_pri[1]))
    else $error("chain out of priority order");

  // Tag and count pairs are unique, so an update hits exactly one cell.
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EXEC) && (req_mode == MODE_INSERT) && any_match) |-> $onehot(c_match))
    else $error("more than one cell matches an insert");

endmodule

// ===== src/bpq_cell.sv =====
module bpq_cell
  import bpq_pkg::*;
#(
  parameter int TAG_WIDTH      = 16,
  parameter int PRIORITY_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cell_ctl_t                 ctl,
  input  logic [TAG_WIDTH-1:0]      key_tag,
  input  logic [CNT_W-1:0]          key_cnt,
  input  logic [PRIORITY_WIDTH-1:0] key_pri,
  input  logic                      up_valid,
  input  logic                      up_goes,
  input  logic [TAG_WIDTH-1:0]      up_tag,
  input  logic [CNT_W-1:0]          up_cnt,
  input  logic [PRIORITY_WIDTH-1:0] up_pri,
  input  logic                      dn_valid,
  input  logic [TAG_WIDTH-1:0]      dn_tag,
  input  logic [CNT_W-1:0]          dn_cnt,
  input  logic [PRIORITY_WIDTH-1:0] dn_pri,
  input  logic                      shift_in,
  output logic                      valid,
  output logic [TAG_WIDTH-1:0]      tag,
  output logic [CNT_W-1:0]          cnt,
  output logic [PRIORITY_WIDTH-1:0] pri,
  output logic                      goes,
  output logic                      match,
  output logic                      tail,
  output logic                      shift_out
);

  logic                      valid_next;
  logic [TAG_WIDTH-1:0]      tag_next;
  logic [CNT_W-1:0]          cnt_next;
  logic [PRIORITY_WIDTH-1:0] pri_next;
  logic                      hit;

  // Local compares against the broadcast key; none of these depend on ctl.
  always_comb begin
    match = valid && (tag == key_tag) && (cnt == key_cnt);
    tail  = valid && !dn_valid;
    goes  = valid && (pri >= key_pri);
  end

  // A removal starts at the hit cell and everything below moves up one place.
  always_comb begin
    hit = ((ctl.sel == SEL_MATCH) && match) || ((ctl.sel == SEL_LAST) && tail);
    shift_out = shift_in || hit;
  end

  // Next contents of the cell.
  always_comb begin
    valid_next = valid;
    tag_next   = tag;
    cnt_next   = cnt;
    pri_next   = pri;
    unique case (ctl.op)
      OP_INSERT: begin
        // Entries with a greater or equal priority stay; the first cell past
        // them takes the key and the rest take their upper neighbor.
        if (!goes) begin
          valid_next = valid || up_valid;
          if (up_goes) begin
            tag_next = key_tag;
            cnt_next = key_cnt;
            pri_next = key_pri;
          end else begin
            tag_next = up_tag;
            cnt_next = up_cnt;
            pri_next = up_pri;
          end
        end
      end
      OP_REMOVE: begin
        if (shift_out) begin
          valid_next = dn_valid;
          tag_next   = dn_tag;
          cnt_next   = dn_cnt;
          pri_next   = dn_pri;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    tag <= tag_next;
    cnt <= cnt_next;
    pri <= pri_next;
  end

endmodule
